// File: src/sse_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sse_pkg
// Shared constants and types for the smoothstep easing curve core.
// ---------------------------------------------------------------------------
package sse_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int FW            = FRACTION_BITS + 1;
    localparam int POS_W         = 16;
    localparam int MAG_W         = POS_W;
    localparam int QUO_W         = FRACTION_BITS;
    localparam int DIV_STAGES    = QUO_W;
    localparam int ACC_W         = FW + 8;

    localparam logic [FW-1:0] ONE_Q = FW'(1) << FRACTION_BITS;

    typedef enum logic [1:0]
    {
        ORDER_3RD = 2'd0,
        ORDER_5TH = 2'd1,
        ORDER_7TH = 2'd2,
        ORDER_RSV = 2'd3
    } order_t;

    typedef enum logic [1:0]
    {
        REG_START = 2'd0,
        REG_END   = 2'd1,
        REG_ORDER = 2'd2
    } reg_idx_t;

    typedef struct packed
    {
        logic [FW-1:0] t;
        order_t        order;
    } poly_in_t;

endpackage

// File: src/sse_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sse_divider
// Ramp fraction: sign handling, clamp and a restoring divider, one quotient
// bit per stage.
// ---------------------------------------------------------------------------
module sse_divider
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [sse_pkg::POS_W-1:0]    position,
    input  logic [sse_pkg::POS_W-1:0]    ramp_start,
    input  logic [sse_pkg::POS_W-1:0]    ramp_end,
    input  sse_pkg::order_t              order,
    output logic                         out_valid,
    output sse_pkg::poly_in_t            out_data
);

    localparam int N  = sse_pkg::DIV_STAGES;
    localparam int MW = sse_pkg::MAG_W;
    localparam int FW = sse_pkg::FW;

    // stage 0 registers
    logic          v0_reg;
    logic [MW-1:0] num0_reg;
    logic [MW-1:0] den0_reg;
    logic          fix0_reg;
    logic [FW-1:0] fixv0_reg;
    sse_pkg::order_t ord0_reg;

    logic signed [MW:0] n_s;
    logic signed [MW:0] d_s;
    logic [MW-1:0]      un;
    logic [MW-1:0]      ud;
    logic               fix_next;
    logic [FW-1:0]      fixv_next;

    always_comb
    begin
        n_s = $signed({1'b0, position}) - $signed({1'b0, ramp_start});
        d_s = $signed({1'b0, ramp_end}) - $signed({1'b0, ramp_start});
        un  = n_s[MW] ? MW'(-n_s) : n_s[MW-1:0];
        ud  = d_s[MW] ? MW'(-d_s) : d_s[MW-1:0];
        fix_next  = 1'b1;
        fixv_next = '0;
        if (d_s == '0)
        begin
            fixv_next = (position >= ramp_start) ? sse_pkg::ONE_Q : '0;
        end
        else if (n_s == '0 || (n_s[MW] != d_s[MW]))
        begin
            fixv_next = '0;
        end
        else if (un >= ud)
        begin
            fixv_next = sse_pkg::ONE_Q;
        end
        else
        begin
            fix_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        num0_reg  <= un;
        den0_reg  <= ud;
        fix0_reg  <= fix_next;
        fixv0_reg <= fixv_next;
        ord0_reg  <= order;
    end

    // divider stages; remainder < den so MW bits hold it, the doubled trial takes MW+1
    logic [N:0]        v_reg;
    logic [MW-1:0]     rem_reg  [N+1];
    logic [MW-1:0]     den_reg  [N+1];
    logic [N-1:0]      quo_reg  [N+1];
    logic              fix_reg  [N+1];
    logic [FW-1:0]     fixv_reg [N+1];
    sse_pkg::order_t   ord_reg  [N+1];

    always_comb
    begin
        v_reg[0]    = v0_reg;
        rem_reg[0]  = num0_reg;
        den_reg[0]  = den0_reg;
        quo_reg[0]  = '0;
        fix_reg[0]  = fix0_reg;
        fixv_reg[0] = fixv0_reg;
        ord_reg[0]  = ord0_reg;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [MW:0] trial;
        logic        ge;
        assign trial = {rem_reg[i], 1'b0};
        assign ge    = trial >= {1'b0, den_reg[i]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i+1]  <= ge ? MW'(trial - {1'b0, den_reg[i]}) : trial[MW-1:0];
            den_reg[i+1]  <= den_reg[i];
            quo_reg[i+1]  <= {quo_reg[i][N-2:0], ge};
            fix_reg[i+1]  <= fix_reg[i];
            fixv_reg[i+1] <= fixv_reg[i];
            ord_reg[i+1]  <= ord_reg[i];
        end
    end

    assign out_valid      = v_reg[N];
    assign out_data.t     = fix_reg[N] ? fixv_reg[N] : {1'b0, quo_reg[N]};
    assign out_data.order = ord_reg[N];

endmodule

// File: src/sse_poly.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sse_poly
// Power chain, one truncated multiply per stage, then weighted sum and clamp.
// ---------------------------------------------------------------------------
module sse_poly
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  sse_pkg::poly_in_t         in_data,
    output logic                      out_valid,
    output logic [sse_pkg::FW-1:0]    eased_value,
    output logic [sse_pkg::FW-1:0]    linear_fraction
);

    localparam int FW = sse_pkg::FW;
    localparam int FB = sse_pkg::FRACTION_BITS;
    localparam int AW = sse_pkg::ACC_W;
    localparam int NP = 7;

    // p_reg[s][k] holds t^(k+1) for k <= s; stage s has powers up to s+1
    logic [NP-1:0]     v_reg;
    logic [FW-1:0]     p_reg [NP][NP];
    sse_pkg::order_t   ord_reg [NP];

    always_comb
    begin
        v_reg[0] = in_valid;
        for (int k = 0; k < NP; k++)
        begin
            p_reg[0][k] = in_data.t;
        end
        ord_reg[0] = in_data.order;
    end

    for (genvar s = 1; s < NP; s++)
    begin : g_pow
        logic [2*FW-1:0] prod;
        assign prod = p_reg[s-1][s-1] * p_reg[s-1][0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            for (int k = 0; k < NP; k++)
            begin
                if (k == s)
                begin
                    p_reg[s][k] <= prod[FB +: FW];
                end
                else
                begin
                    p_reg[s][k] <= p_reg[s-1][k];
                end
            end
            ord_reg[s] <= ord_reg[s-1];
        end
    end

    logic signed [AW-1:0] p2, p3, p4, p5, p6, p7;
    logic signed [AW-1:0] sum;
    logic [FW-1:0]        clamped;

    always_comb
    begin
        p2 = $signed(AW'(p_reg[NP-1][1]));
        p3 = $signed(AW'(p_reg[NP-1][2]));
        p4 = $signed(AW'(p_reg[NP-1][3]));
        p5 = $signed(AW'(p_reg[NP-1][4]));
        p6 = $signed(AW'(p_reg[NP-1][5]));
        p7 = $signed(AW'(p_reg[NP-1][6]));
        case (ord_reg[NP-1])
            sse_pkg::ORDER_3RD: sum = AW'(3 * p2 - 2 * p3);
            sse_pkg::ORDER_5TH: sum = AW'(6 * p5 - 15 * p4 + 10 * p3);
            default:            sum = AW'(-20 * p7 + 70 * p6 - 84 * p5 + 35 * p4);
        endcase
        if (sum < 0)
        begin
            clamped = '0;
        end
        else if (sum > $signed(AW'(sse_pkg::ONE_Q)))
        begin
            clamped = sse_pkg::ONE_Q;
        end
        else
        begin
            clamped = sum[FW-1:0];
        end
    end

    logic          vo_reg;
    logic [FW-1:0] eased_reg;
    logic [FW-1:0] lin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vo_reg <= 1'b0;
        end
        else
        begin
            vo_reg <= v_reg[NP-1];
        end
    end

    always_ff @(posedge clk)
    begin
        eased_reg <= clamped;
        lin_reg   <= p_reg[NP-1][0];
    end

    assign out_valid       = vo_reg;
    assign eased_value     = eased_reg;
    assign linear_fraction = lin_reg;

endmodule

// File: src/smoothstep_easing_curve_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smoothstep_easing_curve_core
// Maps a position onto a configured ramp and applies an easing polynomial.
//
//  channel   signals                                  dir
//  command   start, busy, position                    in
//  result    done, eased_value, linear_fraction       out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in
//
// One beat per cycle; busy is always low. The divider resolves one quotient
// bit per stage, then the power chain, the weighted sum and the clamp follow.
// Reset clears valid bits and sets the config registers to their reset values.
// The receiver cannot stall; results show for one cycle with done.
// ---------------------------------------------------------------------------
module smoothstep_easing_curve_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [sse_pkg::POS_W-1:0]         position,
    output logic                              done,
    output logic [sse_pkg::FW-1:0]            eased_value,
    output logic [sse_pkg::FW-1:0]            linear_fraction,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data
);

    logic [sse_pkg::POS_W-1:0] start_reg;
    logic [sse_pkg::POS_W-1:0] end_reg;
    sse_pkg::order_t           order_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '1;
            order_reg <= sse_pkg::ORDER_3RD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sse_pkg::REG_START: start_reg <= cfg_data;
                sse_pkg::REG_END:   end_reg   <= cfg_data;
                sse_pkg::REG_ORDER: order_reg <= sse_pkg::order_t'(cfg_data[1:0]);
                default:            ;
            endcase
        end
    end

    logic              div_valid;
    sse_pkg::poly_in_t div_data;

    sse_divider u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start && !busy),
        .position   (position),
        .ramp_start (start_reg),
        .ramp_end   (end_reg),
        .order      (order_reg),
        .out_valid  (div_valid),
        .out_data   (div_data)
    );

    sse_poly u_poly
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (div_valid),
        .in_data         (div_data),
        .out_valid       (done),
        .eased_value     (eased_value),
        .linear_fraction (linear_fraction)
    );

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> linear_fraction <= sse_pkg::ONE_Q)
        else $error("fraction out of range");
    a_eased_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> eased_value <= sse_pkg::ONE_Q)
        else $error("eased value out of range");
    a_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (linear_fraction == '0 || linear_fraction == sse_pkg::ONE_Q))
        |-> eased_value == linear_fraction)
        else $error("curve endpoints wrong");

endmodule
